>>> hw/rtl/spq_pkg.sv
// Package: types, opcodes and defaults shared by the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } spq_op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] operand_value;
  } spq_in_t;

  typedef struct packed {
    logic               success;
    logic               overflow;
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [4:0]         entry_count;
    logic               full_res;
  } spq_out_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert, store not full
    logic rem;  // remove, match present
  } spq_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/spq_cell.sv
// One storage cell of the sorted chain: holds a value and its occupied flag.
`default_nettype none
module spq_cell #(
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire spq_pkg::spq_cmd_t     cmd,
  input  wire logic [VALUE_BITS-1:0] operand,
  input  wire logic                  left_lt,
  input  wire logic                  left_occ,
  input  wire logic [VALUE_BITS-1:0] left_val,
  input  wire logic                  right_occ,
  input  wire logic [VALUE_BITS-1:0] right_val,
  output logic                       lt,
  output logic                       eq,
  output logic                       occ,
  output logic [VALUE_BITS-1:0]      val,
  output logic                       occ_nxt_o,
  output logic [VALUE_BITS-1:0]      val_nxt_o
);

  logic                  occ_r, occ_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;

  assign lt  = occ_r && ($signed(val_r) < $signed(operand));
  assign eq  = occ_r && (val_r == operand);
  assign occ = occ_r;
  assign val = val_r;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (cmd.ins && !lt) begin
      // open a slot: new value lands where the left neighbor is still smaller
      occ_nxt = left_lt ? 1'b1 : left_occ;
      val_nxt = left_lt ? operand : left_val;
    end else if (cmd.rem && !lt) begin
      occ_nxt = right_occ;
      val_nxt = right_val;
    end
  end

  assign occ_nxt_o = occ_nxt;
  assign val_nxt_o = val_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/sorted_priority_queue_core.sv
// Top level: sorted priority queue built from a chain of compare-and-shift cells.
`default_nettype none
// Sorted priority queue. Holds up to CAPACITY signed VALUE_BITS-bit values in
// ascending order (duplicates kept) in a row of cells. Each item is one
// operation: insert, remove one matching value, or find a value. The operand
// is broadcast to every cell; each cell compares it with its own value and
// then keeps its value, takes the operand, or takes its left or right
// neighbor's value, so insert and remove update all cells at once whatever
// the fill level. Because the row stays sorted, equal entries sit side by
// side and the first match is the first cell that is not smaller. Throughput
// is one item per clock while not stalled, and the result item is registered
// on acceptance; a new item is accepted in the same cycle that the previous
// result leaves, and in_stall is raised only while that register is full and
// stalled. Every result reports the head (minimum), head valid, count and
// full flag after the operation. An insert into a full store sets overflow
// and changes nothing; opcode 3 changes nothing. Operands wider than
// VALUE_BITS are cut to their low VALUE_BITS bits; head_value is the stored
// value zero-extended or cut to 32 bits.
module sorted_priority_queue_core #(
  parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire spq_pkg::spq_in_t in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output spq_pkg::spq_out_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  // Handshake
  logic accept;
  logic out_valid_r, out_valid_nxt;
  spq_pkg::spq_out_t out_item_r, out_item_nxt;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Operand, cut to the stored width
  logic [EXT_W-1:0]      op_ext;
  logic [VALUE_BITS-1:0] operand;
  assign op_ext  = EXT_W'($unsigned(in_item.operand_value));
  assign operand = op_ext[VALUE_BITS-1:0];

  // Cell chain wiring
  logic [CAPACITY-1:0]   lt_v, eq_v, occ_v, occ_nxt_v;
  logic [VALUE_BITS-1:0] val_v     [CAPACITY];
  logic [VALUE_BITS-1:0] val_nxt_v [CAPACITY];

  logic full, found;
  spq_pkg::spq_cmd_t cmd;
  logic is_ins, is_rem, is_find;

  assign full    = occ_v[CAPACITY-1];
  assign found   = |eq_v;
  assign is_ins  = accept && (in_item.opcode == spq_pkg::OP_INSERT);
  assign is_rem  = accept && (in_item.opcode == spq_pkg::OP_REMOVE);
  assign is_find = accept && (in_item.opcode == spq_pkg::OP_FIND);
  assign cmd.ins = is_ins && !full;
  assign cmd.rem = is_rem && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_lt, l_occ, r_occ;
    logic [VALUE_BITS-1:0] l_val, r_val;
    if (i == 0) begin : g_first
      // nothing to the left: head cell takes the operand when not smaller
      assign l_lt  = 1'b1;
      assign l_occ = 1'b1;
      assign l_val = operand;
    end else begin : g_mid_l
      assign l_lt  = lt_v[i-1];
      assign l_occ = occ_v[i-1];
      assign l_val = val_v[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_occ = 1'b0;
      assign r_val = val_v[i];
    end else begin : g_mid_r
      assign r_occ = occ_v[i+1];
      assign r_val = val_v[i+1];
    end

    spq_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .operand  (operand),
      .left_lt  (l_lt),
      .left_occ (l_occ),
      .left_val (l_val),
      .right_occ(r_occ),
      .right_val(r_val),
      .lt       (lt_v[i]),
      .eq       (eq_v[i]),
      .occ      (occ_v[i]),
      .val      (val_v[i]),
      .occ_nxt_o(occ_nxt_v[i]),
      .val_nxt_o(val_nxt_v[i])
    );
  end

  // Entry count
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result item, built from the post-operation state
  logic [EXT_W-1:0] head_ext;
  assign head_ext = EXT_W'(val_nxt_v[0]);

  always_comb begin
    out_item_nxt.success     = cmd.ins || cmd.rem || (is_find && found);
    out_item_nxt.overflow    = is_ins && full;
    out_item_nxt.head_valid  = occ_nxt_v[0];
    out_item_nxt.head_value  = occ_nxt_v[0] ? head_ext[31:0] : 32'sd0;
    out_item_nxt.entry_count = 5'(count_nxt);
    out_item_nxt.full_res    = occ_nxt_v[CAPACITY-1];
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Checks
  a_count_matches_occ: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(occ_v)))
    else $error("entry count disagrees with occupied cells");

  a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_v >> 1) & ~occ_v) == '0)
    else $error("occupied cells not packed toward the head");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.overflow |-> out_item_r.full_res && !out_item_r.success)
    else $error("overflow reported while store not full");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted insert did not grow the count");

endmodule
`default_nettype wire
